[rtl/ffa_pkg.sv]
// ---------------------------------------------------------------------------
// ffa_pkg: shared types and constants of the first-fit heap allocator
// Block table entry layout, status codes and sequencer states.
// ---------------------------------------------------------------------------
package ffa_pkg;

    localparam int HEAP_BYTES   = 4096;
    localparam int HEADER_BYTES = 12;
    localparam int MAX_BLOCKS   = 64;

    localparam int IDX_W  = $clog2(MAX_BLOCKS);
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int LEN_W  = 12;
    localparam int SIZE_W = 13;
    localparam int ST_W   = 2;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_NOFIT   = 2'd1;
    localparam logic [ST_W-1:0] ST_BADADDR = 2'd2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic [LEN_W-1:0] start;
        logic [LEN_W-1:0] len;
        logic             free;
    } ffa_entry_t;

    localparam ffa_entry_t RESET_ENTRY = '{
        start: '0,
        len:   LEN_W'(HEAP_BYTES - HEADER_BYTES),
        free:  1'b1
    };

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [LEN_W-1:0] offset;
    } ffa_result_t;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        ffa_entry_t       wr_data;
    } ffa_mem_req_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_EX,
        S_NXT_RD,
        S_NXT_EX,
        S_MERGE,
        S_SHU_RD,
        S_SHU_WR,
        S_WR_A,
        S_WR_B,
        S_DRP_RD,
        S_DRP_WR,
        S_DONE
    } ffa_state_t;

endpackage

[rtl/ffa_table.sv]
// ---------------------------------------------------------------------------
// ffa_table: block table memory
// One write and one registered read per cycle; entry zero reads as the
// initial whole-heap block until it is first written.
// ---------------------------------------------------------------------------
module ffa_table
    import ffa_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  ffa_mem_req_t req,
    output ffa_entry_t   rdata
);

    ffa_entry_t mem [MAX_BLOCKS];
    ffa_entry_t rdata_reg;
    logic       zero_wr_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            if (req.rd_addr == '0 && !zero_wr_reg)
            begin
                rdata_reg <= RESET_ENTRY;
            end
            else
            begin
                rdata_reg <= mem[req.rd_addr];
            end
        end
    end

    // entry zero becomes real once written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_wr_reg <= 1'b0;
        end
        else if (req.wr_en && req.wr_addr == '0)
        begin
            zero_wr_reg <= 1'b1;
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/ffa_ctrl.sv]
// ---------------------------------------------------------------------------
// ffa_ctrl: allocator sequencer
// Walks the table one entry at a time, splits on allocate, joins
// neighbors on free, and shifts entries one at a time with a read and a write.
// ---------------------------------------------------------------------------
module ffa_ctrl
    import ffa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              op,
    input  logic [SIZE_W-1:0] size,
    input  logic [SIZE_W-1:0] addr,
    input  logic              slot_free,
    input  ffa_entry_t        rdata,
    output logic              idle,
    output logic              done,
    output ffa_result_t       result,
    output ffa_mem_req_t      mem_req
);

    ffa_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic [CNT_W-1:0]  sh_reg;
    logic [1:0]        drop_reg;
    logic              op_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [SIZE_W-1:0] addr_reg;
    ffa_entry_t        cur_reg, prev_reg, nxt_reg;
    ffa_result_t       res_reg;

    logic              has_prev, has_next;
    logic [LEN_W-1:0]  join_len;
    logic              ex_match, ex_exact, ex_split;
    logic [SIZE_W:0]   size_hdr;
    logic [CNT_W:0]    drop_src;
    logic              nxt_exists;

    localparam logic [LEN_W-1:0]  HDR_L = LEN_W'(HEADER_BYTES);
    localparam logic [SIZE_W-1:0] HDR_S = SIZE_W'(HEADER_BYTES);

    assign has_prev   = (idx_reg != '0) && prev_reg.free;
    assign has_next   = nxt_reg.free;
    assign join_len   = cur_reg.len + (has_prev ? prev_reg.len + HDR_L : '0)
                                    + (has_next ? nxt_reg.len + HDR_L : '0);
    assign size_hdr   = {1'b0, size_reg} + (SIZE_W+1)'(HEADER_BYTES);
    assign ex_exact   = rdata.free && ({1'b0, rdata.len} == size_reg);
    assign ex_split   = rdata.free && ({2'b0, rdata.len} > size_hdr)
                        && (cnt_reg < CNT_W'(MAX_BLOCKS));
    assign ex_match   = ({1'b0, rdata.start} + HDR_S) == addr_reg;
    assign drop_src   = {1'b0, sh_reg} + (CNT_W+1)'(drop_reg);
    assign nxt_exists = (idx_reg + 1'b1) < cnt_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (start) state_next = S_RD;
            S_RD:     state_next = (idx_reg == cnt_reg) ? S_DONE : S_EX;
            S_EX:
            begin
                if (op_reg == OP_ALLOC)
                begin
                    if (ex_exact)      state_next = S_WR_B;
                    else if (ex_split) state_next = S_SHU_RD;
                    else               state_next = S_RD;
                end
                else
                begin
                    if (!ex_match)       state_next = S_RD;
                    else if (nxt_exists) state_next = S_NXT_RD;
                    else                 state_next = S_MERGE;
                end
            end
            S_NXT_RD: state_next = S_NXT_EX;
            S_NXT_EX: state_next = S_MERGE;
            S_MERGE:  state_next = (has_prev || has_next) ? S_DRP_RD : S_DONE;
            S_SHU_RD: state_next = (sh_reg > idx_reg) ? S_SHU_WR : S_WR_A;
            S_SHU_WR: state_next = S_SHU_RD;
            S_WR_A:   state_next = S_WR_B;
            S_WR_B:   state_next = S_DONE;
            S_DRP_RD: state_next = (drop_src < {1'b0, cnt_reg}) ? S_DRP_WR : S_DONE;
            S_DRP_WR: state_next = S_DRP_RD;
            S_DONE:   if (slot_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // memory requests
    always_comb
    begin
        mem_req = '0;
        unique case (state_reg)
            S_RD:
            begin
                mem_req.rd_en   = (idx_reg != cnt_reg);
                mem_req.rd_addr = idx_reg[IDX_W-1:0];
            end
            S_NXT_RD:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = IDX_W'(idx_reg + 1'b1);
            end
            S_MERGE:
            begin
                mem_req.wr_en         = 1'b1;
                mem_req.wr_addr       = has_prev ? IDX_W'(idx_reg - 1'b1)
                                                 : idx_reg[IDX_W-1:0];
                mem_req.wr_data.start = has_prev ? prev_reg.start : cur_reg.start;
                mem_req.wr_data.len   = join_len;
                mem_req.wr_data.free  = 1'b1;
            end
            S_SHU_RD:
            begin
                mem_req.rd_en   = (sh_reg > idx_reg);
                mem_req.rd_addr = sh_reg[IDX_W-1:0];
            end
            S_SHU_WR:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = IDX_W'(sh_reg + 1'b1);
                mem_req.wr_data = rdata;
            end
            S_WR_A:
            begin
                mem_req.wr_en         = 1'b1;
                mem_req.wr_addr       = IDX_W'(idx_reg + 1'b1);
                mem_req.wr_data.start = cur_reg.start + HDR_L + size_reg[LEN_W-1:0];
                mem_req.wr_data.len   = cur_reg.len - size_reg[LEN_W-1:0] - HDR_L;
                mem_req.wr_data.free  = 1'b1;
            end
            S_WR_B:
            begin
                mem_req.wr_en         = 1'b1;
                mem_req.wr_addr       = idx_reg[IDX_W-1:0];
                mem_req.wr_data.start = cur_reg.start;
                mem_req.wr_data.len   = size_reg[LEN_W-1:0];
                mem_req.wr_data.free  = 1'b0;
            end
            S_DRP_RD:
            begin
                mem_req.rd_en   = (drop_src < {1'b0, cnt_reg});
                mem_req.rd_addr = drop_src[IDX_W-1:0];
            end
            S_DRP_WR:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = sh_reg[IDX_W-1:0];
                mem_req.wr_data = rdata;
            end
            default: mem_req = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= CNT_W'(1);
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_WR_A)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (state_reg == S_DRP_RD && !(drop_src < {1'b0, cnt_reg}))
            begin
                cnt_reg <= cnt_reg - CNT_W'(drop_reg);
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                op_reg        <= op;
                size_reg      <= size;
                addr_reg      <= addr;
                idx_reg       <= '0;
                prev_reg      <= '0;
                res_reg       <= '0;
            end
            S_RD:
            begin
                if (idx_reg == cnt_reg)
                begin
                    res_reg.status <= (op_reg == OP_FREE) ? ST_BADADDR : ST_NOFIT;
                end
            end
            S_EX:
            begin
                cur_reg <= rdata;
                if (op_reg == OP_ALLOC)
                begin
                    if (ex_split)
                    begin
                        sh_reg <= cnt_reg - 1'b1;
                    end
                    else if (!ex_exact)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                else if (!ex_match)
                begin
                    prev_reg <= rdata;
                    idx_reg  <= idx_reg + 1'b1;
                end
                else
                begin
                    nxt_reg <= '0;
                end
            end
            S_NXT_EX: nxt_reg <= rdata;
            S_MERGE:
            begin
                res_reg.status <= ST_OK;
                sh_reg   <= has_prev ? idx_reg : idx_reg + 1'b1;
                drop_reg <= {1'b0, has_prev} + {1'b0, has_next};
            end
            S_SHU_WR: sh_reg <= sh_reg - 1'b1;
            S_WR_B:
            begin
                res_reg.status <= ST_OK;
                res_reg.offset <= cur_reg.start + HDR_L;
            end
            S_DRP_WR: sh_reg <= sh_reg + 1'b1;
            default: ;
        endcase
    end

    assign idle   = (state_reg == S_IDLE);
    assign done   = (state_reg == S_DONE) && slot_free;
    assign result = res_reg;

endmodule

[rtl/first_fit_heap_allocator.sv]
// ---------------------------------------------------------------------------
// first_fit_heap_allocator: first-fit heap allocator over a block table
// Sequencer plus table memory (one read and one write port) plus one result register.
// ---------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_ channel: tuser[0] is the operation (0 allocate,
//   1 free), tdata carries the request size and the payload address. Each
//   request yields exactly one result transfer on the m_ channel with a
//   status and the granted payload offset (zero unless an allocate is ok).
//   The block handles one request at a time; s_tready is high only while the
//   sequencer is idle. Each table entry visited in the first-fit or address
//   search takes a memory read then a compare. An allocate that splits a
//   block shifts each entry above it up with a read and a write, then writes
//   the two halves. A free reads the next neighbor when one exists and
//   writes the joined entry; if it joins neighbors, the entries above it are
//   shifted down with a read and a write each.
//   After reset the table holds one free block covering the whole heap; no
//   clearing pass is needed. A finished result is held in the output
//   register, and a new request is taken while it waits; the next result
//   waits in the sequencer until the receiver takes the held one.
// ---------------------------------------------------------------------------
module first_fit_heap_allocator
    import ffa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [12:0] request_size, [25:13] address, rest zero
    input  logic [0:0]  s_tuser,   // [0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [1:0] status, [13:2] payload_offset, rest zero
);

    ffa_entry_t   rdata;
    ffa_mem_req_t mem_req;
    ffa_result_t  result;
    ffa_result_t  out_reg;
    logic         out_valid_reg;
    logic         idle, done, slot_free;

    // result slot frees up when empty or drained this cycle
    assign slot_free = !out_valid_reg || m_tready;
    assign s_tready  = idle;

    ffa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (s_tvalid && idle),
        .op        (s_tuser[0]),
        .size      (s_tdata[SIZE_W-1:0]),
        .addr      (s_tdata[2*SIZE_W-1:SIZE_W]),
        .slot_free (slot_free),
        .rdata     (rdata),
        .idle      (idle),
        .done      (done),
        .result    (result),
        .mem_req   (mem_req)
    );

    ffa_table u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mem_req),
        .rdata (rdata)
    );

    // hold the result until the receiver takes the transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg.offset, out_reg.status};

endmodule
